>>> rtl/pmmn_pkg.sv
`default_nettype none

package pmmn_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int VAL_BITS      = SAMPLE_BITS + 1;
  localparam int SPAN_BITS     = SAMPLE_BITS + 2;
  localparam int GAIN_BITS     = 32;
  localparam int NUM_BITS      = VAL_BITS + FRACTION_BITS + 1;
  localparam int PROD_BITS     = VAL_BITS + GAIN_BITS - 1;
  localparam int RND_BITS      = PROD_BITS - FRACTION_BITS + 1;
  localparam int SRND_BITS     = RND_BITS + 1;
  localparam int SUM_BITS      = SRND_BITS + 1;
  localparam int CNT_BITS      = $clog2(NUM_BITS + 1);

  localparam int MQ_DEPTH      = 2;
  localparam int OQ_DEPTH      = 4;
  localparam int OQ_CNT_BITS   = $clog2(OQ_DEPTH + 1);

  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MIN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MAX   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_MODE = 2'd2;

  localparam logic [1:0] MODE_DARK  = 2'd0;
  localparam logic [1:0] MODE_LIGHT = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_SCALE   = 1'b1;

  localparam logic [GAIN_BITS-1:0] GAIN_CAP = {1'b0, {(GAIN_BITS-1){1'b1}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [VAL_BITS-1:0]    val_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;

  typedef struct packed {
    logic    func;
    sample_t sample;
    logic    last;
  } in_t;

  typedef struct packed {
    sample_t scaled;
    logic    degenerate;
    logic    last_out;
  } out_t;

  typedef struct packed {
    sample_t    out_min;
    sample_t    out_max;
    logic [1:0] line_mode;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic last;
    logic zero;
    logic keep_low;
    val_t val;
  } item_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_PREP,
    BK_DIV,
    BK_GAIN,
    BK_OMUL,
    BK_OFS
  } bk_state_t;

  function automatic sample_t sat_sample(input logic signed [SUM_BITS-1:0] v);
    sample_t res;
    res = v[SAMPLE_BITS-1:0];
    if (!v[SUM_BITS-1] && (|v[SUM_BITS-2:SAMPLE_BITS-1])) begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v[SUM_BITS-1] && !(&v[SUM_BITS-2:SAMPLE_BITS-1])) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
    return res;
  endfunction

  function automatic logic [VAL_BITS-1:0] mag_val(input val_t v);
    val_t neg;
    neg = -v;
    return v[VAL_BITS-1] ? neg : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/polarity_min_max_normalizer_top.sv
// Polarity min/max normalizer, signed Q8.16 samples.
// Input queue: in_push/in_full/in_data. A transaction with func=0 is a
// measure-pass sample and gives no result; func=1 is a scale-pass sample
// and gives one result on out_data (pop with out_pop while out_empty low).
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 out_min,
// 1 out_max, 2 line_mode; cfg_ready is always high. Write only when idle.
// Throughput: one transaction per cycle while in_full is low. A scale
// sample goes through the mid queue, product register and output queue.
// The measure sample with last=1 starts the gain computation: a radix-2
// restoring divider, one quotient bit per cycle over 42 bits, plus one
// multiply for the offset. Later transactions wait in a 2-entry queue
// meanwhile, then in_full rises.
// Results sit in a 4-entry output queue; while the receiver stalls and it
// fills, scale samples hold in the middle queue and in_full rises.
// Reset (rst_n low, synchronous) empties both queues, sets out_min 0,
// out_max 1.0, line_mode 2, gain and offset 0 and starts a new frame.
`default_nettype none

module polarity_min_max_normalizer_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_push,
  output logic                                        in_full,
  input  wire pmmn_pkg::in_t                          in_data,
  output logic                                        out_empty,
  input  wire logic                                   out_pop,
  output pmmn_pkg::out_t                              out_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pmmn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [pmmn_pkg::SAMPLE_BITS-1:0]       cfg_data
);

  localparam int IW = $bits(pmmn_pkg::item_t);
  localparam int OW = $bits(pmmn_pkg::out_t);

  pmmn_pkg::cfg_t  cfg_r;
  pmmn_pkg::item_t fr_item;
  pmmn_pkg::item_t mq_item;
  pmmn_pkg::out_t  res;
  logic            fr_wr;
  logic            mq_empty;
  logic            mq_pop;
  logic [IW-1:0]   mq_rd_data;
  logic            res_wr;
  logic [OW-1:0]   oq_rd_data;
  logic [pmmn_pkg::OQ_CNT_BITS-1:0] oq_cnt;

  assign cfg_ready = 1'b1;
  assign mq_item   = pmmn_pkg::item_t'(mq_rd_data);
  assign out_data  = pmmn_pkg::out_t'(oq_rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_min   <= '0;
      cfg_r.out_max   <= pmmn_pkg::sample_t'(1) <<< pmmn_pkg::FRACTION_BITS;
      cfg_r.line_mode <= pmmn_pkg::MODE_BOTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmmn_pkg::CFG_OUT_MIN:   cfg_r.out_min   <= cfg_data;
        pmmn_pkg::CFG_OUT_MAX:   cfg_r.out_max   <= cfg_data;
        pmmn_pkg::CFG_LINE_MODE: cfg_r.line_mode <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  pmmn_front u_front (
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .wr      (fr_wr),
    .item    (fr_item)
  );

  pmmn_fifo #(
    .WIDTH (IW),
    .DEPTH (pmmn_pkg::MQ_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fr_wr),
    .wr_data (fr_item),
    .rd      (mq_pop),
    .rd_data (mq_rd_data),
    .full    (in_full),
    .empty   (mq_empty),
    .count   ()
  );

  pmmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (mq_item),
    .mid_empty (mq_empty),
    .mid_pop   (mq_pop),
    .out_cnt   (oq_cnt),
    .res_wr    (res_wr),
    .res       (res)
  );

  pmmn_fifo #(
    .WIDTH (OW),
    .DEPTH (pmmn_pkg::OQ_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .wr_data (res),
    .rd      (out_pop),
    .rd_data (oq_rd_data),
    .full    (),
    .empty   (out_empty),
    .count   (oq_cnt)
  );

endmodule

`default_nettype wire

>>> rtl/pmmn_fifo.sv
`default_nettype none

module pmmn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr,
  input  wire logic [WIDTH-1:0]             wr_data,
  input  wire logic                         rd,
  output logic      [WIDTH-1:0]             rd_data,
  output logic                              full,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == CNT_BITS'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pmmn_front.sv
`default_nettype none

module pmmn_front (
  input  wire pmmn_pkg::cfg_t  cfg,
  input  wire logic            in_push,
  input  wire logic            in_full,
  input  wire pmmn_pkg::in_t   in_data,
  output logic                 wr,
  output pmmn_pkg::item_t      item
);

  pmmn_pkg::val_t sx;
  pmmn_pkg::val_t val;
  logic           zero;

  assign sx = pmmn_pkg::VAL_BITS'(in_data.sample);
  assign wr = in_push && !in_full;

  always_comb begin
    unique case (cfg.line_mode) inside
      pmmn_pkg::MODE_LIGHT: begin
        val  = sx;
        zero = in_data.sample[pmmn_pkg::SAMPLE_BITS-1] || (in_data.sample == '0);
      end
      pmmn_pkg::MODE_BOTH: begin
        val  = sx[pmmn_pkg::VAL_BITS-1] ? -sx : sx;
        zero = 1'b0;
      end
      pmmn_pkg::MODE_DARK, pmmn_pkg::MODE_SPARE: begin
        val  = -sx;
        zero = !in_data.sample[pmmn_pkg::SAMPLE_BITS-1];
      end
      default: begin
        val  = -sx;
        zero = !in_data.sample[pmmn_pkg::SAMPLE_BITS-1];
      end
    endcase
  end

  always_comb begin
    item.func     = in_data.func;
    item.last     = in_data.last;
    item.zero     = zero;
    item.keep_low = (cfg.line_mode == pmmn_pkg::MODE_BOTH);
    item.val      = val;
  end

endmodule

`default_nettype wire

>>> rtl/pmmn_back.sv
`default_nettype none

module pmmn_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pmmn_pkg::cfg_t                      cfg,
  input  wire pmmn_pkg::item_t                     item,
  input  wire logic                                mid_empty,
  output logic                                     mid_pop,
  input  wire logic [pmmn_pkg::OQ_CNT_BITS-1:0]    out_cnt,
  output logic                                     res_wr,
  output pmmn_pkg::out_t                           res
);

  localparam int VB = pmmn_pkg::VAL_BITS;
  localparam int SB = pmmn_pkg::SPAN_BITS;
  localparam int GB = pmmn_pkg::GAIN_BITS;
  localparam int NB = pmmn_pkg::NUM_BITS;
  localparam int PB = pmmn_pkg::PROD_BITS;
  localparam int RB = pmmn_pkg::RND_BITS;
  localparam int QB = pmmn_pkg::SRND_BITS;
  localparam int UB = pmmn_pkg::SUM_BITS;
  localparam int CB = pmmn_pkg::CNT_BITS;
  localparam int FB = pmmn_pkg::FRACTION_BITS;

  pmmn_pkg::bk_state_t state_r, state_nxt;
  pmmn_pkg::val_t      lo_r, lo_nxt;
  pmmn_pkg::val_t      hi_r, hi_nxt;
  pmmn_pkg::gain_t     gain_r, gain_nxt;
  pmmn_pkg::sample_t   offset_r, offset_nxt;
  logic                span_bad_r, span_bad_nxt;
  logic                fresh_r, fresh_nxt;
  pmmn_pkg::val_t      diff_r, diff_nxt;
  pmmn_pkg::sample_t   omax_r, omax_nxt;
  logic [SB-1:0]       d_r, d_nxt;
  logic [NB-1:0]       num_r, num_nxt;
  logic [SB-1:0]       rem_r, rem_nxt;
  logic [CB-1:0]       cnt_r, cnt_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic                p_ofs_r, p_ofs_nxt;
  logic [PB-1:0]       p_r, p_nxt;
  logic                p_neg_r, p_neg_nxt;
  logic                p_zero_r, p_zero_nxt;
  logic                p_last_r, p_last_nxt;

  logic                   room;
  pmmn_pkg::val_t         mul_src;
  pmmn_pkg::gain_t        gneg;
  logic [GB-2:0]          gmag;
  logic [RB-1:0]          m;
  logic signed [QB-1:0]   sm;
  logic signed [UB-1:0]   sum_s;
  logic signed [UB-1:0]   ofs_s;
  pmmn_pkg::val_t         lo_u, hi_u;
  logic signed [SB-1:0]   span;
  logic [SB:0]            rem_sh;
  logic                   qbit;
  logic [GB:0]            rq;
  logic [GB-1:0]          g;

  assign room = ({1'b0, out_cnt} + (pmmn_pkg::OQ_CNT_BITS+1)'(p_vld_r))
                < (pmmn_pkg::OQ_CNT_BITS+1)'(pmmn_pkg::OQ_DEPTH);

  assign gneg  = -gain_r;
  assign gmag  = gain_r[GB-1] ? gneg[GB-2:0] : gain_r[GB-2:0];

  // rounding half away from zero on the magnitude
  assign m     = RB'(p_r >> FB) + RB'(p_r[FB-1]);
  assign sm    = p_neg_r ? -$signed({1'b0, m}) : $signed({1'b0, m});
  assign sum_s = UB'(sm) + UB'(offset_r);
  assign ofs_s = UB'(omax_r) - UB'(sm);

  assign lo_u  = fresh_r ? item.val : ((item.val < lo_r) ? item.val : lo_r);
  assign hi_u  = fresh_r ? item.val : ((item.val > hi_r) ? item.val : hi_r);
  assign span  = SB'(hi_r) - SB'(lo_r);

  assign rem_sh = {rem_r, num_r[NB-1]};
  assign qbit   = (rem_sh >= {1'b0, d_r});
  assign rq     = {1'b0, num_r[GB-1:0]} + (GB+1)'(1);

  always_comb begin
    if (|num_r[NB-1:GB]) begin
      g = pmmn_pkg::GAIN_CAP;
    end else if (rq[GB]) begin
      g = pmmn_pkg::GAIN_CAP;
    end else begin
      g = rq[GB:1];
    end
  end

  always_comb begin
    res.scaled     = p_zero_r   ? '0 :
                     span_bad_r ? cfg.out_min : pmmn_pkg::sat_sample(sum_s);
    res.degenerate = span_bad_r;
    res.last_out   = p_last_r;
    res_wr         = p_vld_r && !p_ofs_r;
  end

  always_comb begin
    state_nxt    = state_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    gain_nxt     = gain_r;
    offset_nxt   = offset_r;
    span_bad_nxt = span_bad_r;
    fresh_nxt    = fresh_r;
    diff_nxt     = diff_r;
    omax_nxt     = omax_r;
    d_nxt        = d_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    p_vld_nxt    = 1'b0;
    p_ofs_nxt    = 1'b0;
    p_zero_nxt   = item.zero;
    p_last_nxt   = item.last;
    mul_src      = item.val;
    mid_pop      = 1'b0;

    unique case (state_r)
      pmmn_pkg::BK_RUN: begin
        if (!mid_empty) begin
          if (item.func == pmmn_pkg::FUNC_SCALE) begin
            if (room) begin
              mid_pop   = 1'b1;
              p_vld_nxt = 1'b1;
            end
          end else begin
            mid_pop   = 1'b1;
            lo_nxt    = lo_u;
            hi_nxt    = hi_u;
            fresh_nxt = 1'b0;
            if (item.last) begin
              if (!item.keep_low) begin
                lo_nxt = '0;
              end
              fresh_nxt = 1'b1;
              diff_nxt  = VB'(cfg.out_max) - VB'(cfg.out_min);
              omax_nxt  = cfg.out_max;
              state_nxt = pmmn_pkg::BK_PREP;
            end
          end
        end
      end
      pmmn_pkg::BK_PREP: begin
        if (span[SB-1] || (span == '0)) begin
          span_bad_nxt = 1'b1;
          gain_nxt     = '0;
          offset_nxt   = '0;
          state_nxt    = pmmn_pkg::BK_RUN;
        end else begin
          span_bad_nxt = 1'b0;
          d_nxt        = span;
          num_nxt      = {pmmn_pkg::mag_val(diff_r), {(FB+1){1'b0}}};
          rem_nxt      = '0;
          cnt_nxt      = CB'(NB);
          state_nxt    = pmmn_pkg::BK_DIV;
        end
      end
      pmmn_pkg::BK_DIV: begin
        rem_nxt = qbit ? SB'(rem_sh - {1'b0, d_r}) : rem_sh[SB-1:0];
        num_nxt = {num_r[NB-2:0], qbit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CB'(1)) begin
          state_nxt = pmmn_pkg::BK_GAIN;
        end
      end
      pmmn_pkg::BK_GAIN: begin
        gain_nxt  = diff_r[VB-1] ? -pmmn_pkg::gain_t'(g) : pmmn_pkg::gain_t'(g);
        state_nxt = pmmn_pkg::BK_OMUL;
      end
      pmmn_pkg::BK_OMUL: begin
        mul_src   = hi_r;
        p_vld_nxt = 1'b1;
        p_ofs_nxt = 1'b1;
        state_nxt = pmmn_pkg::BK_OFS;
      end
      pmmn_pkg::BK_OFS: begin
        offset_nxt = pmmn_pkg::sat_sample(ofs_s);
        state_nxt  = pmmn_pkg::BK_RUN;
      end
      default: begin
        state_nxt = pmmn_pkg::BK_RUN;
      end
    endcase

    p_nxt     = PB'(pmmn_pkg::mag_val(mul_src)) * PB'(gmag);
    p_neg_nxt = mul_src[VB-1] ^ gain_r[GB-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pmmn_pkg::BK_RUN;
      lo_r       <= {1'b0, {(VB-1){1'b1}}};
      hi_r       <= {1'b1, {(VB-1){1'b0}}};
      gain_r     <= '0;
      offset_r   <= '0;
      span_bad_r <= 1'b0;
      fresh_r    <= 1'b1;
      p_vld_r    <= 1'b0;
      p_ofs_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
      gain_r     <= gain_nxt;
      offset_r   <= offset_nxt;
      span_bad_r <= span_bad_nxt;
      fresh_r    <= fresh_nxt;
      p_vld_r    <= p_vld_nxt;
      p_ofs_r    <= p_ofs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    omax_r   <= omax_nxt;
    d_r      <= d_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    p_r      <= p_nxt;
    p_neg_r  <= p_neg_nxt;
    p_zero_r <= p_zero_nxt;
    p_last_r <= p_last_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/pmmn_checker.sv
`default_nettype none

module pmmn_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_push,
  input wire logic                              in_full,
  input wire logic                              out_empty,
  input wire logic                              out_pop,
  input wire pmmn_pkg::out_t                    out_data
);

  // right after reset the outputs stay empty and in_full starts low
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full ##1 out_empty)
    else $error("result or full flag right after reset");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full && !in_push |=> !in_full)
    else $error("in_full rose without a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("stalled result changed or vanished");

endmodule

bind polarity_min_max_normalizer_top pmmn_checker u_pmmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
